### hdl/bcc_pkg.sv
// bcc_pkg: shared types and constants for the branch coverage counter
// holds the queue entry and configuration structs and register index codes
// no dependencies
package bcc_pkg;

    localparam int ADDR_W    = 32;
    localparam int POS_W     = 18;
    localparam int LEN_W     = 5;
    localparam int CNT_W     = 32;
    localparam int RUN_W     = 48;
    localparam int IDX_W     = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_REGION_BEGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_OFFSET = 2'd2;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] region_begin;
        logic [ADDR_W-1:0] region_end;
        logic [POS_W-1:0]  index_offset;
    } t_cfg;

    typedef struct packed {
        logic              kind;
        logic              src_ok;
        logic              tgt_ok;
        logic [IDX_W-1:0]  src_idx;
        logic [IDX_W-1:0]  tgt_idx;
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
        logic              cond;
        logic [ADDR_W-1:0] limit;
    } t_entry;

endpackage

### hdl/bcc_front.sv
// bcc_front: input handshake and item classification
// rebases record addresses, clamps query length, computes the query bound
// depends on bcc_pkg
module bcc_front
    import bcc_pkg::*;
#(
    parameter int TABLE_DEPTH    = 262144,
    parameter int MAX_INST_BYTES = 16
) (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_kind,
    input  logic [ADDR_W-1:0] i_source_addr,
    input  logic [ADDR_W-1:0] i_target_addr,
    input  logic [POS_W-1:0]  i_inst_position,
    input  logic [LEN_W-1:0]  i_inst_bytes,
    input  logic              i_is_conditional,
    input  t_cfg              i_cfg,
    input  logic              i_queue_full,
    input  logic              i_clear_done,
    output logic              o_push,
    output t_entry            o_entry
);

    logic [ADDR_W-1:0] src_rebased;
    logic [ADDR_W-1:0] tgt_rebased;
    logic              src_in_region;
    logic              tgt_in_region;

    assign o_in_ready = !i_queue_full && i_clear_done;
    assign o_push     = i_in_valid && o_in_ready;

    assign src_in_region = (i_source_addr >= i_cfg.region_begin)
                        && (i_source_addr < i_cfg.region_end);
    assign tgt_in_region = (i_target_addr >= i_cfg.region_begin)
                        && (i_target_addr < i_cfg.region_end);
    assign src_rebased = i_source_addr - i_cfg.region_begin + ADDR_W'(i_cfg.index_offset);
    assign tgt_rebased = i_target_addr - i_cfg.region_begin + ADDR_W'(i_cfg.index_offset);

    always_comb begin
        o_entry.kind    = i_kind;
        o_entry.src_ok  = src_in_region && (src_rebased < ADDR_W'(TABLE_DEPTH));
        o_entry.tgt_ok  = tgt_in_region && (tgt_rebased < ADDR_W'(TABLE_DEPTH));
        o_entry.src_idx = src_rebased[IDX_W-1:0];
        o_entry.tgt_idx = tgt_rebased[IDX_W-1:0];
        o_entry.pos     = i_inst_position;
        o_entry.cond    = i_is_conditional;
        o_entry.limit   = i_cfg.region_end - i_cfg.region_begin
                        + ADDR_W'(i_cfg.index_offset);
        // clamp long instructions
        if ({1'b0, i_inst_bytes} > (LEN_W + 1)'(MAX_INST_BYTES)) begin
            o_entry.len = LEN_W'(MAX_INST_BYTES);
        end else begin
            o_entry.len = i_inst_bytes;
        end
    end

endmodule

### hdl/bcc_queue.sv
// bcc_queue: two-entry queue of classified items between front and back
// depends on bcc_pkg
module bcc_queue
    import bcc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_push_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_head
);

    t_entry     r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

### hdl/bcc_back.sv
// bcc_back: counter memories, record updates, query summing and result register
// clears both memories after reset, one entry per cycle
// depends on bcc_pkg
module bcc_back
    import bcc_pkg::*;
#(
    parameter int TABLE_DEPTH    = 262144,
    parameter int MAX_INST_BYTES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_entry           i_head,
    output logic             o_pop,
    output logic             o_clear_done,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [RUN_W-1:0] o_run_count,
    output logic [RUN_W-1:0] o_taken_count,
    output logic [RUN_W-1:0] o_not_taken_count,
    output logic             o_partly_covered,
    output logic             o_never_run
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = CNT_W + $clog2(MAX_INST_BYTES + 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_REC_RD = 3'd2;
    localparam logic [2:0] S_REC_WR = 3'd3;
    localparam logic [2:0] S_SUM    = 3'd4;
    localparam logic [2:0] S_UPD    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [CNT_W-1:0] r_dep_mem [TABLE_DEPTH];
    logic [CNT_W-1:0] r_arr_mem [TABLE_DEPTH];
    logic [CNT_W-1:0] r_dep_rd;
    logic [CNT_W-1:0] r_arr_rd;

    logic [2:0]       r_state;
    logic [AW-1:0]    r_clr;
    t_entry           r_ent;
    logic [LEN_W-1:0] r_step;
    logic             r_acc_en;
    logic [SW-1:0]    r_dep_sum;
    logic [SW-1:0]    r_arr_sum;
    logic [RUN_W-1:0] r_run;

    logic [ADDR_W-1:0] byte_pos;
    logic              byte_ok;
    logic [AW-1:0]     dep_rd_addr;
    logic [AW-1:0]     arr_rd_addr;
    logic [AW-1:0]     dep_wr_addr;
    logic [AW-1:0]     arr_wr_addr;
    logic [CNT_W-1:0]  dep_wdata;
    logic [CNT_W-1:0]  arr_wdata;
    logic              dep_we;
    logic              arr_we;
    logic              out_load;
    logic [RUN_W-1:0]  dep_sum_ext;

    assign byte_pos     = ADDR_W'(r_ent.pos) + ADDR_W'(r_step);
    assign byte_ok      = (byte_pos < r_ent.limit) && (byte_pos < ADDR_W'(TABLE_DEPTH));
    assign o_pop        = (r_state == S_IDLE) && !i_empty;
    assign o_clear_done = (r_state != S_CLEAR);
    assign out_load     = (r_state == S_OUT) && (!o_out_valid || i_out_ready);
    assign dep_sum_ext  = RUN_W'(r_dep_sum);

    always_comb begin
        if (r_state == S_SUM) begin
            dep_rd_addr = byte_pos[AW-1:0];
            arr_rd_addr = byte_pos[AW-1:0];
        end else begin
            dep_rd_addr = r_ent.src_idx[AW-1:0];
            arr_rd_addr = r_ent.tgt_idx[AW-1:0];
        end
        if (r_state == S_CLEAR) begin
            dep_we      = 1'b1;
            arr_we      = 1'b1;
            dep_wr_addr = r_clr;
            arr_wr_addr = r_clr;
            dep_wdata   = '0;
            arr_wdata   = '0;
        end else begin
            dep_we      = (r_state == S_REC_WR) && r_ent.src_ok;
            arr_we      = (r_state == S_REC_WR) && r_ent.tgt_ok;
            dep_wr_addr = r_ent.src_idx[AW-1:0];
            arr_wr_addr = r_ent.tgt_idx[AW-1:0];
            // saturating increment
            dep_wdata   = (r_dep_rd == '1) ? r_dep_rd : r_dep_rd + CNT_W'(1);
            arr_wdata   = (r_arr_rd == '1) ? r_arr_rd : r_arr_rd + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (dep_we) begin
            r_dep_mem[dep_wr_addr] <= dep_wdata;
        end
        r_dep_rd <= r_dep_mem[dep_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (arr_we) begin
            r_arr_mem[arr_wr_addr] <= arr_wdata;
        end
        r_arr_rd <= r_arr_mem[arr_rd_addr];
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_run_count       <= r_run;
            o_never_run       <= (r_run == '0);
            if (r_ent.cond) begin
                o_taken_count     <= dep_sum_ext;
                o_not_taken_count <= r_run - dep_sum_ext;
                o_partly_covered  <= (r_dep_sum == '0) || (r_run == dep_sum_ext);
            end else begin
                o_taken_count     <= '0;
                o_not_taken_count <= '0;
                o_partly_covered  <= 1'b0;
            end
        end
        if (o_pop) begin
            r_ent <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_step      <= '0;
            r_acc_en    <= 1'b0;
            r_dep_sum   <= '0;
            r_arr_sum   <= '0;
            r_run       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (r_acc_en) begin
                r_dep_sum <= r_dep_sum + SW'(r_dep_rd);
                r_arr_sum <= r_arr_sum + SW'(r_arr_rd);
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(TABLE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_step    <= '0;
                    r_acc_en  <= 1'b0;
                    r_dep_sum <= '0;
                    r_arr_sum <= '0;
                    if (!i_empty) begin
                        r_state <= (i_head.kind == KIND_QUERY) ? S_SUM : S_REC_RD;
                    end
                end
                S_REC_RD: begin
                    r_state <= S_REC_WR;
                end
                S_REC_WR: begin
                    r_state <= S_IDLE;
                end
                S_SUM: begin
                    if (r_step != r_ent.len) begin
                        r_step   <= r_step + LEN_W'(1);
                        r_acc_en <= byte_ok;
                    end else begin
                        r_acc_en <= 1'b0;
                        r_state  <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_run   <= r_run + RUN_W'(r_arr_sum);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_run   <= r_run - dep_sum_ext;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/branch_coverage_counter.sv
// branch_coverage_counter: branch trace histogram with per-instruction coverage queries
// top level: configuration registers, front classifier, queue and back end
// depends on bcc_pkg, bcc_front, bcc_queue, bcc_back
//
//   channel   handshake                   payload
//   input     i_in_valid / o_in_ready     i_kind .. i_is_conditional
//   result    o_out_valid / i_out_ready   o_run_count .. o_never_run
//   config    i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// in the back end a record beat passes through queue pop, counter read and counter write
// a query beat reads both counter memories once per byte of its clamped length
// after reset both counter memories are cleared, one entry a cycle, all TABLE_DEPTH entries;
// no input beat is accepted until the clear finishes
// the two-entry queue lets the front accept beats while the back end or result stalls
module branch_coverage_counter
    import bcc_pkg::*;
#(
    parameter int TABLE_DEPTH    = 262144,
    parameter int MAX_INST_BYTES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_kind,
    input  logic [ADDR_W-1:0]    i_source_addr,
    input  logic [ADDR_W-1:0]    i_target_addr,
    input  logic [POS_W-1:0]     i_inst_position,
    input  logic [LEN_W-1:0]     i_inst_bytes,
    input  logic                 i_is_conditional,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [RUN_W-1:0]     o_run_count,
    output logic [RUN_W-1:0]     o_taken_count,
    output logic [RUN_W-1:0]     o_not_taken_count,
    output logic                 o_partly_covered,
    output logic                 o_never_run,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    t_cfg   r_cfg;
    t_entry push_entry;
    t_entry head;
    logic   push;
    logic   pop;
    logic   queue_full;
    logic   queue_empty;
    logic   clear_done;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_REGION_BEGIN: r_cfg.region_begin <= i_cfg_data;
                REG_REGION_END:   r_cfg.region_end   <= i_cfg_data;
                REG_INDEX_OFFSET: r_cfg.index_offset <= i_cfg_data[POS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bcc_front #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .MAX_INST_BYTES (MAX_INST_BYTES)
    ) u_front (
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_source_addr    (i_source_addr),
        .i_target_addr    (i_target_addr),
        .i_inst_position  (i_inst_position),
        .i_inst_bytes     (i_inst_bytes),
        .i_is_conditional (i_is_conditional),
        .i_cfg            (r_cfg),
        .i_queue_full     (queue_full),
        .i_clear_done     (clear_done),
        .o_push           (push),
        .o_entry          (push_entry)
    );

    bcc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .o_full       (queue_full),
        .i_pop        (pop),
        .o_empty      (queue_empty),
        .o_head       (head)
    );

    bcc_back #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .MAX_INST_BYTES (MAX_INST_BYTES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (queue_empty),
        .i_head            (head),
        .o_pop             (pop),
        .o_clear_done      (clear_done),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_run_count       (o_run_count),
        .o_taken_count     (o_taken_count),
        .o_not_taken_count (o_not_taken_count),
        .o_partly_covered  (o_partly_covered),
        .o_never_run       (o_never_run)
    );

endmodule
